[design/dq_pkg.sv]
// dq_pkg: shared types and constants for the double-ended queue
// command and status codes, controller states, the pointer unit's update struct
// no dependencies
package dq_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_PUSH_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_LOAD
  } fsm_t;

  typedef struct packed {
    logic    wr_en;
    status_t status;
  } upd_t;

endpackage

[design/dq_if.sv]
// dq_in_if and dq_out_if: valid/ready channels for commands and results
// depends on dq_pkg for field widths
interface dq_in_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::CMD_W-1:0]            cmd;
  logic signed [dq_pkg::VALUE_W-1:0]   push_value;

  modport source (output valid, cmd, push_value, input ready);
  modport sink   (input valid, cmd, push_value, output ready);
endinterface

interface dq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dq_pkg::VALUE_W-1:0]   front_value;
  logic signed [dq_pkg::VALUE_W-1:0]   back_value;
  logic [dq_pkg::COUNT_W-1:0]          entry_count;
  logic                                is_empty;
  logic [dq_pkg::STATUS_W-1:0]         status;

  modport source (output valid, front_value, back_value, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, front_value, back_value, entry_count, is_empty, status,
                  output ready);
endinterface

[design/double_ended_queue_top.sv]
// double_ended_queue_top: bounded deque of signed 32-bit values, one result per command
// depends on dq_pkg, dq_if, dq_ram and dq_ptr
//
// Each command passes in turn through S_IDLE, S_WAIT and S_LOAD; its result is offered
// on out_ch once it is in the output register. The transfer cycle updates the pointers
// and writes the store. The next cycle presents the new front and back slots to the two
// store copies, whose read data is registered. In S_LOAD, once the output register is
// free or is being emptied, that read data is loaded into it. The next command is taken
// as soon as the result has moved into the output register, even if it has not yet been
// taken. The store is held twice so that front and back are read in the same cycle; its
// contents need no clearing after reset.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fsm_t                       state_r;
  fsm_t                       state_nxt;
  logic                       accept;
  logic                       load;
  upd_t                       upd;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              front_ptr;
  logic [AW-1:0]              back_ptr;
  logic [CW-1:0]              count;
  logic [CW+COUNT_W-1:0]      count_ext;
  logic [VALUE_W-1:0]         front_rd;
  logic [VALUE_W-1:0]         back_rd;
  status_t                    status_r;
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  front_value_r;
  logic signed [VALUE_W-1:0]  back_value_r;
  logic [COUNT_W-1:0]         entry_count_r;
  logic                       is_empty_r;
  status_t                    out_status_r;
  logic                       result_empty;

  assign accept = in_ch.valid && in_ch.ready;

  dq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (accept),
    .op_cmd   (cmd_t'(in_ch.cmd)),
    .upd      (upd),
    .waddr    (waddr),
    .front_r  (front_ptr),
    .back_r   (back_ptr),
    .count_r  (count)
  );

  // front copy
  dq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_front (
    .clk     (clk),
    .we      (upd.wr_en),
    .waddr   (waddr),
    .wdata   (in_ch.push_value),
    .raddr   (front_ptr),
    .rdata_r (front_rd)
  );

  // back copy
  dq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_back (
    .clk     (clk),
    .we      (upd.wr_en),
    .waddr   (waddr),
    .wdata   (in_ch.push_value),
    .raddr   (back_ptr),
    .rdata_r (back_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    load        = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_LOAD: begin
        load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= upd.status;
    end
  end

  assign result_empty = (count == '0);
  assign count_ext    = {{COUNT_W{1'b0}}, count};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_value_r <= result_empty ? '0 : front_rd;
      back_value_r  <= result_empty ? '0 : back_rd;
      entry_count_r <= count_ext[COUNT_W-1:0];
      is_empty_r    <= result_empty;
      out_status_r  <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = front_value_r;
  assign out_ch.back_value  = back_value_r;
  assign out_ch.entry_count = entry_count_r;
  assign out_ch.is_empty    = is_empty_r;
  assign out_ch.status      = out_status_r;

endmodule

[design/dq_ram.sv]
// dq_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[design/dq_ptr.sv]
// dq_ptr: front/back pointers and entry count of the circular store
// decides the store write slot and the status of each command; depends on dq_pkg
module dq_ptr #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  input  dq_pkg::cmd_t               op_cmd,
  output dq_pkg::upd_t               upd,
  output logic [$clog2(DEPTH)-1:0]   waddr,
  output logic [$clog2(DEPTH)-1:0]   front_r,
  output logic [$clog2(DEPTH)-1:0]   back_r,
  output logic [$clog2(DEPTH+1)-1:0] count_r
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] front_nxt;
  logic [AW-1:0] back_nxt;
  logic [CW-1:0] count_nxt;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] back_inc;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] back_dec;
  logic          empty;
  logic          full;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign back_dec  = (back_r == '0) ? AW'(DEPTH - 1) : back_r - AW'(1);
  assign back_inc  = (back_r == AW'(DEPTH - 1)) ? '0 : back_r + AW'(1);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    waddr      = front_r;
    upd.wr_en  = 1'b0;
    upd.status = STAT_OK;
    case (op_cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          upd.status = STAT_PUSH_FULL;
        end else if (empty) begin
          waddr     = front_r;
          back_nxt  = front_r;
          count_nxt = CW'(1);
          upd.wr_en = op_valid;
        end else if (op_cmd == CMD_PUSH_FRONT) begin
          front_nxt = front_dec;
          waddr     = front_dec;
          count_nxt = count_r + CW'(1);
          upd.wr_en = op_valid;
        end else begin
          back_nxt  = back_inc;
          waddr     = back_inc;
          count_nxt = count_r + CW'(1);
          upd.wr_en = op_valid;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          upd.status = STAT_POP_EMPTY;
        end else begin
          if (count_r > CW'(1)) begin
            if (op_cmd == CMD_POP_FRONT) begin
              front_nxt = front_inc;
            end else begin
              back_nxt = back_dec;
            end
          end
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_CLEAR: begin
        front_nxt = '0;
        back_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (op_valid) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[tb/double_ended_queue_top_tb.sv]
// double_ended_queue_top_tb: self-checking bench for the bounded deque, directed rows then
// random command traffic with idling, output back-pressure and a full drain pause
// depends on dq_pkg, dq_if and double_ended_queue_top
module double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HOLD_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MODE_LEN      = 25;

  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sd0;
  localparam logic signed [VALUE_W-1:0] VAL_ONES = -32'sd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    status_t                   status;
  } dq_result_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        fixed_exp;
    dq_result_t                res;
  } stim_row_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  localparam dq_result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  in_ch();
  dq_out_if out_ch();

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [VALUE_W-1:0] slots [DEPTH];
  int unsigned               head_ptr;
  int unsigned               tail_ptr;
  int unsigned               fill;

  dq_result_t pending_results[$];
  int         errors;
  int         quiet_cycles;
  bit         idle_en;
  bit         hold_req;

  function automatic dq_result_t mk_res(logic signed [VALUE_W-1:0] f, logic signed [VALUE_W-1:0] b,
                                        int n, bit e, status_t s);
    dq_result_t r;
    r.front_value = f;
    r.back_value  = b;
    r.entry_count = COUNT_W'(n);
    r.is_empty    = e;
    r.status      = s;
    return r;
  endfunction

  function automatic dq_result_t deque_apply(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v);
    dq_result_t r;
    status_t    st;
    st = STAT_OK;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          st = STAT_PUSH_FULL;
        end else if (fill == 0) begin
          slots[head_ptr] = v;
          tail_ptr = head_ptr;
          fill = 1;
        end else if (c == CMD_PUSH_FRONT) begin
          head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
          slots[head_ptr] = v;
          fill++;
        end else begin
          tail_ptr = (tail_ptr + 1) % DEPTH;
          slots[tail_ptr] = v;
          fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          st = STAT_POP_EMPTY;
        end else begin
          if (fill > 1) begin
            if (c == CMD_POP_FRONT) head_ptr = (head_ptr + 1) % DEPTH;
            else tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
          end
          fill--;
        end
      end
      CMD_CLEAR: begin
        fill = 0;
        head_ptr = 0;
        tail_ptr = 0;
      end
      default: ;
    endcase
    if (fill == 0) r = mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, st);
    else r = mk_res(slots[head_ptr], slots[tail_ptr], fill, 1'b0, st);
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VAL_ZERO;
      3: return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CMD_RSVD_PICK();
    return CMD_W'($urandom_range(CMD_RSVD_7, CMD_RSVD_5));
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(traffic_mode_t mode);
    int roll;
    int push_pct;
    int pop_pct;
    roll     = $urandom_range(99);
    push_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 40;
    pop_pct  = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 80 : 45;
    if (roll < push_pct) begin
      if ($urandom_range(1)) return CMD_PUSH_FRONT;
      return CMD_PUSH_BACK;
    end
    if (roll < push_pct + pop_pct) begin
      if ($urandom_range(1)) return CMD_POP_FRONT;
      return CMD_POP_BACK;
    end
    if ($urandom_range(1)) return CMD_CLEAR;
    return CMD_CMD_RSVD_PICK();
  endfunction

  // one command transfer, with its expectation queued at the accepting edge
  task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                           input bit fixed_exp = 1'b0, input dq_result_t fixed_res = NO_RES);
    dq_result_t predicted;
    while (idle_en && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.push_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = deque_apply(c, v);
    pending_results.push_back(fixed_exp ? fixed_res : predicted);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [VALUE_W-1:0] exp_v,
                             input logic [VALUE_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
      errors++;
    end
  endtask

  // result receiver, with a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= !idle_en || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dq_result_t exp_res;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual front %h back %h count %0d",
                 $time, out_ch.front_value, out_ch.back_value, out_ch.entry_count);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("front_value", exp_res.front_value, out_ch.front_value);
        check_field("back_value", exp_res.back_value, out_ch.back_value);
        check_field("entry_count", exp_res.entry_count, out_ch.entry_count);
        check_field("is_empty", exp_res.is_empty, out_ch.is_empty);
        check_field("status", exp_res.status, out_ch.status);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t     rows[$];
    traffic_mode_t mode;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_PUSH_FRONT;
    in_ch.push_value = VAL_ZERO;
    idle_en          = 1'b1;
    hold_req         = 1'b0;
    errors           = 0;
    quiet_cycles     = 0;
    head_ptr         = 0;
    tail_ptr         = 0;
    fill             = 0;
    mode             = MODE_MIXED;

    rows.push_back('{CMD_POP_FRONT, VAL_ZERO, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_POP_EMPTY)});
    rows.push_back('{CMD_POP_BACK, VAL_ONES, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_POP_EMPTY)});
    rows.push_back('{CMD_PUSH_BACK, VAL_MAX, 1'b1, mk_res(VAL_MAX, VAL_MAX, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_PUSH_FRONT, VAL_MIN, 1'b1, mk_res(VAL_MIN, VAL_MAX, 2, 1'b0, STAT_OK)});
    rows.push_back('{CMD_POP_BACK, VAL_ZERO, 1'b1, mk_res(VAL_MIN, VAL_MIN, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_POP_FRONT, VAL_MAX, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_OK)});
    // refill after the last value left, pointers no longer at slot zero
    rows.push_back('{CMD_PUSH_FRONT, VAL_ONES, 1'b1,
                     mk_res(VAL_ONES, VAL_ONES, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_RSVD_5, 32'sd123, 1'b1, mk_res(VAL_ONES, VAL_ONES, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_RSVD_7, VAL_MAX, 1'b1, mk_res(VAL_ONES, VAL_ONES, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_PUSH_BACK, 32'sh5555_5555, 1'b0, NO_RES});
    rows.push_back('{CMD_PUSH_FRONT, 32'shaaaa_aaaa, 1'b0, NO_RES});
    rows.push_back('{CMD_POP_FRONT, VAL_MAX, 1'b0, NO_RES});
    rows.push_back('{CMD_CLEAR, VAL_MIN, 1'b1, mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_OK)});
    rows.push_back('{CMD_POP_BACK, VAL_ZERO, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_POP_EMPTY)});
    rows.push_back('{CMD_PUSH_BACK, VAL_ZERO, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 1, 1'b0, STAT_OK)});
    rows.push_back('{CMD_PUSH_BACK, VAL_ONES, 1'b0, NO_RES});
    rows.push_back('{CMD_RSVD_6, VAL_ONES, 1'b0, NO_RES});
    rows.push_back('{CMD_POP_BACK, VAL_MIN, 1'b0, NO_RES});
    rows.push_back('{CMD_POP_BACK, VAL_MAX, 1'b0, NO_RES});
    rows.push_back('{CMD_POP_FRONT, VAL_ZERO, 1'b1,
                     mk_res(VAL_ZERO, VAL_ZERO, 0, 1'b1, STAT_POP_EMPTY)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].cmd, rows[i].value, rows[i].fixed_exp, rows[i].res);
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = (i < 150) || (i >= 300);
      if (i % MODE_LEN == 0) mode = traffic_mode_t'($urandom_range(MODE_MIXED, MODE_FILL));
      // long result stall while commands keep coming
      if (i == 250) begin
        hold_req = 1'b1;
        mode     = MODE_FILL;
      end
      if (i == 400) wait_for_results();
      send_item(pick_cmd(mode), pick_value());
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
